// File: hdl/fbfm_pkg.sv
// ----------------------------------------------------------------------------
// fbfm_pkg
// Shared types, constants and the sine table generator for the feedback FM
// sine oscillator.
// ----------------------------------------------------------------------------
package fbfm_pkg;

  localparam int COEF_BITS = 16;
  localparam int AMT_BITS  = 15;

  localparam logic [COEF_BITS-1:0] COEF_RESET = 16'd32768;
  localparam logic [AMT_BITS-1:0]  FB_MAX     = 15'd16384;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_FILT,
    ST_AMT,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_FRAC,
    ST_HOLD
  } state_t;

  // Table entry i of a 2^tb entry sine with amplitude 2^(sb-1)-1.
  // Quarter wave from a Q30 Taylor series, mirrored into the other quadrants.
  function automatic longint sine_entry(int i, int tb, int sb);
    int unsigned       q;
    int unsigned       r;
    int unsigned       rr;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   s;
    longint unsigned   amp;
    longint            sum;
    longint            v;
    q  = i >> (tb - 2);
    r  = i & ((1 << (tb - 2)) - 1);
    rr = q[0] ? (1 << (tb - 2)) - r : r;
    x  = (longint'(rr) * HALF_PI_Q30) >> (tb - 2);
    x2 = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      unique case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (longint'(ONE_Q30) < sum) begin
      sum = longint'(ONE_Q30);
    end
    s   = longint'(sum);
    amp = (64'd1 << (sb - 1)) - 64'd1;
    v   = longint'((s * amp + (64'd1 << 29)) >> 30);
    if (q[1]) begin
      v = -v;
    end
    return v;
  endfunction

endpackage

// File: hdl/feedback_fm_sine_oscillator.sv
// ----------------------------------------------------------------------------
// feedback_fm_sine_oscillator
// Sine oscillator with self FM: lowpassed previous output, scaled by the
// feedback depth, offsets the phase; output by interpolated table lookup.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (LSB up)                       Transfer
// s_*      in   tdata: phase, feedback_amount         s_tvalid & s_tready
// m_*      out  tdata: sample                         m_tvalid & m_tready
// cfg_*    in   cfg_wdata: filter_coefficient         cfg_we
//
// One sample takes three passes through the bit-serial multiplier, each over
// NW = max(16, PHASE_BITS-TABLE_BITS) multiplier bits.
// One sample in flight; s_tready is high only while idle.
// A finished sample waits in the output register while m_tready is low.
// Reset clears filter state, last output and sets the coefficient to 0.5.
// ----------------------------------------------------------------------------
module feedback_fm_sine_oscillator
  import fbfm_pkg::*;
#(
  parameter int TABLE_BITS  = 12,
  parameter int PHASE_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [COEF_BITS-1:0] cfg_wdata,   // filter_coefficient
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [((PHASE_BITS+AMT_BITS+7)/8)*8-1:0] s_tdata,  // phase, feedback_amount
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata           // sample
);

  localparam int OUT_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int TAB_N   = 1 << TABLE_BITS;
  localparam int ST_W    = SAMPLE_BITS + 2;
  localparam int FRAC_W  = PHASE_BITS - TABLE_BITS;
  localparam int NW      = (FRAC_W > COEF_BITS) ? FRAC_W : COEF_BITS;
  localparam int MW      = SAMPLE_BITS + 3;
  localparam int PW      = MW + NW + 1;
  localparam int FBITS   = SAMPLE_BITS + 11;
  localparam int OFF_SHR = (FBITS >= PHASE_BITS) ? FBITS - PHASE_BITS : 0;
  localparam int OFF_SHL = (FBITS >= PHASE_BITS) ? 0 : PHASE_BITS - FBITS;

  localparam logic signed [ST_W+1:0] ST_MAX = {3'b000, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W+1:0] ST_MIN = {3'b111, {(ST_W-1){1'b0}}};

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ST_W+1:0] v);
    priority if (v > ST_MAX) begin
      return ST_MAX[ST_W-1:0];
    end else if (v < ST_MIN) begin
      return ST_MIN[ST_W-1:0];
    end else begin
      return v[ST_W-1:0];
    end
  endfunction

  // sine table with guard entry
  logic signed [SAMPLE_BITS-1:0] sine_rom [0:TAB_N];

  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
    localparam longint ENTRY = sine_entry(gi, TABLE_BITS, SAMPLE_BITS);
    assign sine_rom[gi] = SAMPLE_BITS'(ENTRY);
  end

  state_t state, state_next;

  logic [COEF_BITS-1:0]          coef;
  logic signed [ST_W-1:0]        filter_state;
  logic signed [ST_W-1:0]        last_output;
  logic [PHASE_BITS-1:0]         phase_r;
  logic [AMT_BITS-1:0]           amt_r;
  logic [AMT_BITS-1:0]           amt_in;
  logic signed [ST_W:0]          vn_r;
  logic signed [ST_W-1:0]        y_r;
  logic [PHASE_BITS-1:0]         p_r;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic signed [SAMPLE_BITS-1:0] res;
  logic signed [SAMPLE_BITS-1:0] rom_q;
  logic [TABLE_BITS:0]           rom_addr;

  logic                  mul_start;
  logic signed [MW-1:0]  mul_a;
  logic [NW-1:0]         mul_b;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;

  logic signed [MW-1:0]          diff;
  logic signed [ST_W:0]          vn_now;
  logic signed [ST_W+1:0]        y_sum;
  logic signed [ST_W+1:0]        fs_sum;
  logic [PHASE_BITS-1:0]         off;
  logic [TABLE_BITS-1:0]         idx;
  logic [FRAC_W-1:0]             frac;
  logic signed [SAMPLE_BITS:0]   bma;
  logic signed [SAMPLE_BITS-1:0] s_now;
  logic                          out_free;

  fbfm_serial_mul #(
    .MW (MW),
    .NW (NW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  assign amt_in   = s_tdata[PHASE_BITS +: AMT_BITS];
  assign diff     = {last_output[ST_W-1], last_output} - {filter_state[ST_W-1], filter_state};
  assign vn_now   = (ST_W+1)'(mul_p >>> COEF_BITS);
  assign y_sum    = {vn_now[ST_W], vn_now} + {{2{filter_state[ST_W-1]}}, filter_state};
  assign fs_sum   = {vn_r[ST_W], vn_r} + {{2{y_r[ST_W-1]}}, y_r};
  assign off      = PHASE_BITS'((mul_p >>> OFF_SHR) <<< OFF_SHL);
  assign idx      = p_r[PHASE_BITS-1 -: TABLE_BITS];
  assign frac     = p_r[FRAC_W-1:0];
  assign bma      = {rom_q[SAMPLE_BITS-1], rom_q} - {a_r[SAMPLE_BITS-1], a_r};
  assign s_now    = a_r + SAMPLE_BITS'(mul_p >>> FRAC_W);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_ALPHA;
      ST_ALPHA: if (mul_done) state_next = ST_FILT;
      ST_FILT:  state_next = ST_AMT;
      ST_AMT:   if (mul_done) state_next = ST_RDA;
      ST_RDA:   state_next = ST_RDB;
      ST_RDB:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_FRAC;
      ST_FRAC:  if (mul_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = diff;
    mul_b     = NW'(coef);
    rom_addr  = {1'b0, idx};
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        mul_start = s_tvalid;
      end
      ST_FILT: begin
        mul_start = 1'b1;
        mul_a     = {y_r[ST_W-1], y_r};
        mul_b     = NW'(amt_r);
      end
      ST_RDB: begin
        rom_addr = (TABLE_BITS+1)'(idx) + (TABLE_BITS+1)'(1);
      end
      ST_DIFF: begin
        mul_start = 1'b1;
        mul_a     = {{2{bma[SAMPLE_BITS]}}, bma};
        mul_b     = NW'(frac);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      coef         <= COEF_RESET;
      filter_state <= '0;
      last_output  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        coef <= cfg_wdata;
      end
      if (state == ST_FILT) begin
        filter_state <= sat_st(fs_sum);
      end
      if (state == ST_FRAC && mul_done) begin
        last_output <= {{2{s_now[SAMPLE_BITS-1]}}, s_now};
      end
      if (state == ST_HOLD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= sine_rom[rom_addr];
    if (state == ST_IDLE && s_tvalid) begin
      phase_r <= s_tdata[PHASE_BITS-1:0];
      amt_r   <= (amt_in > FB_MAX) ? FB_MAX : amt_in;
    end
    if (state == ST_ALPHA && mul_done) begin
      vn_r <= vn_now;
      y_r  <= sat_st(y_sum);
    end
    if (state == ST_AMT && mul_done) begin
      p_r <= phase_r + off;
    end
    if (state == ST_RDB) begin
      a_r <= rom_q;
    end
    if (state == ST_FRAC && mul_done) begin
      res <= s_now;
    end
    if (state == ST_HOLD && out_free) begin
      m_tdata <= OUT_W'($unsigned(res));
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_ALPHA || state == ST_AMT || state == ST_FRAC))
    else $error("multiplier finished outside a wait state");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while one is in progress");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_HOLD)
    else $error("output raised outside the hold state");

endmodule

// File: hdl/fbfm_serial_mul.sv
// ----------------------------------------------------------------------------
// fbfm_serial_mul
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned
// multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module fbfm_serial_mul #(
  parameter int MW = 19,
  parameter int NW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [MW-1:0] a,
  input  logic        [NW-1:0] b,
  output logic                 done,
  output logic signed [MW+NW:0] product
);

  localparam int CNT_W = $clog2(NW + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic signed [MW-1:0] mcand;
  logic signed [MW:0]   hi;
  logic        [NW-1:0] lo;
  logic signed [MW:0]   sum;

  assign sum     = hi + (lo[0] ? {mcand[MW-1], mcand} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum >>> 1;
      lo <= {sum[0], lo[NW-1:1]};
    end
  end

endmodule
